/* src/arp_pkg.sv */
`default_nettype none
package arp_pkg;

  localparam int unsigned HdrLen   = 42;
  localparam int unsigned ReplyLen = 60;

  // Register indexes of the configuration port
  typedef enum logic [1:0] {
    CFG_OWN_MAC       = 2'd0,
    CFG_OWN_IP        = 2'd1,
    CFG_ADDRESS_VALID = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_e;

  // Ethernet type, hardware/protocol types and sizes, opcode
  localparam logic [79:0] HDR_REQUEST = 80'h0806_0001_0800_0604_0001;
  localparam logic [79:0] HDR_REPLY   = 80'h0806_0001_0800_0604_0002;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       reply_end;
  } out_item_t;

  // Everything the back end needs to build one reply
  typedef struct packed {
    logic [47:0] sender_mac;
    logic [47:0] own_mac;
    logic [31:0] tgt_ip;
    logic [31:0] sender_ip;
  } reply_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

/* src/arp_front.sv */
`default_nettype none
module arp_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire arp_pkg::in_item_t    in_data_i,
  input  wire logic [47:0]          own_mac_i,
  input  wire logic [31:0]          own_ip_i,
  input  wire logic                 address_valid_i,
  input  wire arp_pkg::q_stat_t     q_stat_i,
  output logic                      push_o,
  output arp_pkg::reply_desc_t      push_desc_o
);

  logic [5:0]  pos_q, pos_d;
  logic        hdr_good_q, hdr_good_d;
  logic        dst_bc_q, dst_bc_d;
  logic        dst_own_q, dst_own_d;
  logic [47:0] src_mac_q, src_mac_d;
  logic [47:0] snd_mac_q, snd_mac_d;
  logic [31:0] snd_ip_q, snd_ip_d;
  logic [31:0] tgt_ip_q, tgt_ip_d;
  logic        accept;
  logic        answer;
  logic [7:0]  b;
  logic [3:0]  hidx;
  logic [7:0]  own_b;
  logic [7:0]  hdr_b;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i & ~in_stall_o;
  assign b          = in_data_i.frame_byte;
  assign hidx       = 4'(pos_q - 6'd12);
  assign own_b      = own_mac_i[{3'd5 - pos_q[2:0], 3'b000} +: 8];
  assign hdr_b      = arp_pkg::HDR_REQUEST[{4'd9 - hidx, 3'b000} +: 8];

  always_comb begin
    pos_d      = pos_q;
    hdr_good_d = hdr_good_q;
    dst_bc_d   = dst_bc_q;
    dst_own_d  = dst_own_q;
    src_mac_d  = src_mac_q;
    snd_mac_d  = snd_mac_q;
    snd_ip_d   = snd_ip_q;
    tgt_ip_d   = tgt_ip_q;
    if (pos_q < 6'd6) begin
      if (b != 8'hff) dst_bc_d = 1'b0;
      if (b != own_b) dst_own_d = 1'b0;
    end else if (pos_q < 6'd12) begin
      src_mac_d = {src_mac_q[39:0], b};
    end else if (pos_q < 6'd22) begin
      if (b != hdr_b) hdr_good_d = 1'b0;
    end else if (pos_q < 6'd28) begin
      snd_mac_d = {snd_mac_q[39:0], b};
    end else if (pos_q < 6'd32) begin
      snd_ip_d = {snd_ip_q[23:0], b};
    end else if (pos_q < 6'd38) begin
      // target hardware address is not checked
    end else if (pos_q < 6'(arp_pkg::HdrLen)) begin
      tgt_ip_d = {tgt_ip_q[23:0], b};
    end
    if (pos_q < 6'(arp_pkg::HdrLen)) pos_d = pos_q + 6'd1;

    answer = address_valid_i
           && (pos_d == 6'(arp_pkg::HdrLen))
           && hdr_good_d
           && (snd_mac_d != 48'd0)
           && !snd_mac_d[40]
           && (snd_mac_d == src_mac_d)
           && (tgt_ip_d == own_ip_i)
           && (snd_mac_d != own_mac_i)
           && (dst_bc_d || dst_own_d)
           && (snd_ip_d != own_ip_i);
  end

  assign push_o                 = accept & in_data_i.frame_end & answer;
  assign push_desc_o.sender_mac = snd_mac_d;
  assign push_desc_o.own_mac    = own_mac_i;
  assign push_desc_o.tgt_ip     = tgt_ip_d;
  assign push_desc_o.sender_ip  = snd_ip_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      hdr_good_q <= 1'b1;
      dst_bc_q   <= 1'b1;
      dst_own_q  <= 1'b1;
    end else if (accept) begin
      if (in_data_i.frame_end) begin
        pos_q      <= '0;
        hdr_good_q <= 1'b1;
        dst_bc_q   <= 1'b1;
        dst_own_q  <= 1'b1;
      end else begin
        pos_q      <= pos_d;
        hdr_good_q <= hdr_good_d;
        dst_bc_q   <= dst_bc_d;
        dst_own_q  <= dst_own_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      src_mac_q <= src_mac_d;
      snd_mac_q <= snd_mac_d;
      snd_ip_q  <= snd_ip_d;
      tgt_ip_q  <= tgt_ip_d;
    end
  end

endmodule
`default_nettype wire

/* src/arp_queue.sv */
`default_nettype none
module arp_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire arp_pkg::reply_desc_t  push_desc_i,
  input  wire logic                  pop_i,
  output arp_pkg::reply_desc_t       pop_desc_o,
  output arp_pkg::q_stat_t           stat_o
);

  // two-entry ring
  arp_pkg::reply_desc_t slot_q [2];
  logic                 wr_q, rd_q;
  logic [1:0]           cnt_q;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign pop_desc_o   = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= push_desc_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule
`default_nettype wire

/* src/arp_back.sv */
`default_nettype none
module arp_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire arp_pkg::q_stat_t      q_stat_i,
  input  wire arp_pkg::reply_desc_t  q_desc_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output arp_pkg::out_item_t         out_data_o
);

  arp_pkg::reply_desc_t desc_q;
  arp_pkg::out_item_t   out_q, out_d;
  logic                 busy_q, busy_d;
  logic                 out_valid_q, out_valid_d;
  logic [5:0]           k_q, k_d;
  logic                 adv;
  logic [335:0]         rhdr;
  logic                 last;

  assign rhdr = {desc_q.sender_mac, desc_q.own_mac, arp_pkg::HDR_REPLY,
                 desc_q.own_mac, desc_q.tgt_ip, desc_q.sender_mac, desc_q.sender_ip};
  assign adv  = ~out_valid_q | ~out_stall_i;
  assign last = (k_q == 6'(arp_pkg::ReplyLen - 1));
  assign pop_o = ~busy_q & ~q_stat_i.empty;

  always_comb begin
    busy_d      = busy_q;
    k_d         = k_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (adv) out_valid_d = 1'b0;
    if (pop_o) begin
      busy_d = 1'b1;
      k_d    = '0;
    end else if (busy_q && adv) begin
      out_valid_d = 1'b1;
      out_d.reply_end = last;
      if (k_q < 6'(arp_pkg::HdrLen)) begin
        out_d.reply_byte = rhdr[{6'd41 - k_q, 3'b000} +: 8];
      end else begin
        out_d.reply_byte = 8'd0;
      end
      k_d = k_q + 6'd1;
      if (last) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (pop_o) desc_q <= q_desc_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

/* src/arp_request_responder_core.sv */
`default_nettype none
// ARP request responder: frame bytes enter one per cycle; the input stalls only
// while two replies are already waiting in the queue between the parser and the
// reply generator. A request that passes every check is answered with a 60-byte
// reply (zero padded): it is queued, taken by the idle generator, and sent one
// byte per cycle as the output side allows. Back-to-back replies are separated by
// a gap while the generator takes the waiting entry. Configuration (own MAC, own
// IP, address valid) is written by index.
module arp_request_responder_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire arp_pkg::in_item_t   in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output arp_pkg::out_item_t       out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [47:0]         cfg_wdata_i
);

  logic [47:0]          own_mac_q;
  logic [31:0]          own_ip_q;
  logic                 addr_valid_q;
  logic                 push, pop;
  arp_pkg::reply_desc_t push_desc, pop_desc;
  arp_pkg::q_stat_t     q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q    <= '0;
      own_ip_q     <= '0;
      addr_valid_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (arp_pkg::cfg_idx_e'(cfg_index_i))
        arp_pkg::CFG_OWN_MAC:       own_mac_q    <= cfg_wdata_i;
        arp_pkg::CFG_OWN_IP:        own_ip_q     <= cfg_wdata_i[31:0];
        arp_pkg::CFG_ADDRESS_VALID: addr_valid_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  arp_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .own_mac_i       (own_mac_q),
    .own_ip_i        (own_ip_q),
    .address_valid_i (addr_valid_q),
    .q_stat_i        (q_stat),
    .push_o          (push),
    .push_desc_o     (push_desc)
  );

  arp_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_desc_i (push_desc),
    .pop_i       (pop),
    .pop_desc_o  (pop_desc),
    .stat_o      (q_stat)
  );

  arp_back u_back (
    .clk_i,
    .rst_ni,
    .q_stat_i  (q_stat),
    .q_desc_i  (pop_desc),
    .pop_o     (pop),
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

endmodule
`default_nettype wire
